// File: rtl/s2c_pkg.sv
// ----------------------------------------------------------------------------
// s2c_pkg - shared types and constants for the seconds-to-calendar converter
// Holds the sequencer state type, the result bundle and the month table.
// ----------------------------------------------------------------------------
package s2c_pkg;

    localparam int CNT_W         = 32;
    localparam int YEAR_SPAN_DEF = 100;
    localparam int STEP_W        = 3;

    localparam logic [CNT_W-1:0] SECS_PER_MIN  = 32'd60;
    localparam logic [CNT_W-1:0] SECS_PER_HOUR = 32'd3600;
    localparam logic [CNT_W-1:0] SECS_PER_DAY  = 32'd86400;
    localparam logic [CNT_W-1:0] SECS_YEAR     = 32'd31536000;  // 365 days
    localparam logic [CNT_W-1:0] SECS_LEAP     = 32'd31622400;  // 366 days

    // First shift of each restoring division (quotient bits minus one)
    localparam logic [STEP_W-1:0] DAY_TOP  = 3'd4;
    localparam logic [STEP_W-1:0] HOUR_TOP = 3'd4;
    localparam logic [STEP_W-1:0] MIN_TOP  = 3'd5;

    localparam logic [3:0] MONTH_LAST = 4'd11;   // December, zero based

    // Saturated time of day for a count beyond the span
    localparam logic [4:0] SAT_DAY_Q = 5'd30;    // day 31, zero based
    localparam logic [4:0] SAT_HOUR  = 5'd23;
    localparam logic [5:0] SAT_MIN   = 6'd59;
    localparam logic [5:0] SAT_SEC   = 6'd59;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_YEAR,
        ST_MONTH,
        ST_DAY,
        ST_HOUR,
        ST_MIN,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic       out_of_range;
        logic [5:0] second;
        logic [5:0] minute;
        logic [4:0] hour;
        logic [4:0] day;
        logic [3:0] month;
        logic [6:0] year;
    } cal_result_t;

    // Length of a month in seconds, month index zero based
    function automatic logic [CNT_W-1:0] month_secs(input logic [3:0] mi, input logic leap);
        logic [CNT_W-1:0] d31;
        logic [CNT_W-1:0] d30;
        logic [CNT_W-1:0] res;
        d31 = 32'd2678400;
        d30 = 32'd2592000;
        case (mi)
            4'd1:    res = leap ? 32'd2505600 : 32'd2419200;
            4'd3:    res = d30;
            4'd5:    res = d30;
            4'd8:    res = d30;
            4'd10:   res = d30;
            default: res = d31;
        endcase
        return res;
    endfunction

endpackage

// File: rtl/s2c_alu.sv
// ----------------------------------------------------------------------------
// s2c_alu - shared compare and subtract unit
// Gives a - b and whether a is at least b; used by every conversion step.
// ----------------------------------------------------------------------------
module s2c_alu
    import s2c_pkg::*;
(
    input  logic [CNT_W-1:0] a,
    input  logic [CNT_W-1:0] b,
    output logic             ge,
    output logic [CNT_W-1:0] diff
);

    logic [CNT_W:0] wide;

    assign wide = {1'b0, a} - {1'b0, b};
    assign ge   = ~wide[CNT_W];
    assign diff = wide[CNT_W-1:0];

endmodule

// File: rtl/s2c_core.sv
// ----------------------------------------------------------------------------
// s2c_core - sequencer and working registers of the converter
// Strips years and months, then divides the rest by restoring steps; saturates a count past the span.
// ----------------------------------------------------------------------------
module s2c_core
    import s2c_pkg::*;
#(
    parameter int YEAR_SPAN = YEAR_SPAN_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [CNT_W-1:0] in_count,
    output logic             res_valid,
    input  logic             res_ready,
    output cal_result_t      res
);

    localparam int YEAR_W = $clog2(YEAR_SPAN + 1);

    state_t state_reg, state_next;

    logic [CNT_W-1:0]  cnt_reg;
    logic [YEAR_W-1:0] year_reg;
    logic [3:0]        month_reg;
    logic [4:0]        day_reg;
    logic [4:0]        hour_reg;
    logic [5:0]        min_reg;
    logic [STEP_W-1:0] step_reg;
    logic              oor_reg;

    logic [CNT_W-1:0] operand;
    logic [CNT_W-1:0] diff;
    logic             ge;
    logic             leap;
    logic             at_span;
    logic             step_end;

    assign leap     = (year_reg[1:0] == 2'b00);
    assign at_span  = (year_reg == YEAR_W'(YEAR_SPAN));
    assign step_end = (step_reg == '0);

    s2c_alu u_alu (
        .a    (cnt_reg),
        .b    (operand),
        .ge   (ge),
        .diff (diff)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (in_valid) state_next = ST_YEAR;
            ST_YEAR: begin
                if (at_span)  state_next = ST_DONE;
                else if (!ge) state_next = ST_MONTH;
            end
            ST_MONTH: if (!ge || month_reg == MONTH_LAST) state_next = ST_DAY;
            ST_DAY:   if (step_end) state_next = ST_HOUR;
            ST_HOUR:  if (step_end) state_next = ST_MIN;
            ST_MIN:   if (step_end) state_next = ST_DONE;
            ST_DONE:  if (res_ready) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // outputs and operand selection
    always_comb begin
        in_ready  = 1'b0;
        res_valid = 1'b0;
        operand   = '0;
        case (state_reg)
            ST_IDLE:  in_ready  = 1'b1;
            ST_YEAR:  operand   = leap ? SECS_LEAP : SECS_YEAR;
            ST_MONTH: operand   = month_secs(month_reg, leap);
            ST_DAY:   operand   = SECS_PER_DAY << step_reg;
            ST_HOUR:  operand   = SECS_PER_HOUR << step_reg;
            ST_MIN:   operand   = SECS_PER_MIN << step_reg;
            ST_DONE:  res_valid = 1'b1;
            default:  operand   = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    cnt_reg   <= in_count;
                    year_reg  <= '0;
                    month_reg <= '0;
                    oor_reg   <= 1'b0;
                end
            end
            ST_YEAR: begin
                if (at_span) begin
                    year_reg  <= YEAR_W'(YEAR_SPAN - 1);
                    month_reg <= MONTH_LAST;
                    day_reg   <= SAT_DAY_Q;
                    hour_reg  <= SAT_HOUR;
                    min_reg   <= SAT_MIN;
                    cnt_reg   <= CNT_W'(SAT_SEC);
                    oor_reg   <= 1'b1;
                end else if (ge) begin
                    cnt_reg  <= diff;
                    year_reg <= year_reg + 1'b1;
                end else begin
                    step_reg <= DAY_TOP;
                end
            end
            ST_MONTH: begin
                if (ge && month_reg != MONTH_LAST) begin
                    cnt_reg   <= diff;
                    month_reg <= month_reg + 1'b1;
                end else begin
                    step_reg <= DAY_TOP;
                end
            end
            ST_DAY: begin
                if (ge) cnt_reg <= diff;
                day_reg  <= {day_reg[3:0], ge};
                step_reg <= step_end ? HOUR_TOP : step_reg - 1'b1;
            end
            ST_HOUR: begin
                if (ge) cnt_reg <= diff;
                hour_reg <= {hour_reg[3:0], ge};
                step_reg <= step_end ? MIN_TOP : step_reg - 1'b1;
            end
            ST_MIN: begin
                if (ge) cnt_reg <= diff;
                min_reg  <= {min_reg[4:0], ge};
                step_reg <= step_reg - 1'b1;
            end
            default: begin
                cnt_reg <= cnt_reg;
            end
        endcase
    end

    always_comb begin
        res.year         = 7'(year_reg);
        res.month        = month_reg + 4'd1;
        res.day          = day_reg + 5'd1;
        res.hour         = hour_reg;
        res.minute       = min_reg;
        res.second       = cnt_reg[5:0];
        res.out_of_range = oor_reg;
    end

endmodule

// File: rtl/seconds_to_calendar.sv
// ----------------------------------------------------------------------------
// seconds_to_calendar - seconds count to two-digit calendar date and time
// Converts seconds since year 00-01-01 00:00:00 into year, month, day,
// hour, minute and second, saturating beyond the last year of the span.
// ----------------------------------------------------------------------------
//
//  Channel  | Ports                      | Word contents (lowest bit first)
//  ---------+----------------------------+-----------------------------------
//  input    | s_tvalid s_tready s_tdata  | seconds_count[31:0]
//  result   | m_tvalid m_tready m_tdata  | year[6:0] month[10:7] day[15:11]
//           | m_tuser                    | hour[20:16] minute[26:21]
//           |                            | second[32:27], zeros to bit 39;
//           |                            | m_tuser = out_of_range
//
//  The sequencer strips whole years (at most YEAR_SPAN - 1) and months
//  (at most 11), leaves each strip loop on a compare that strips nothing,
//  runs 16 restoring division steps, all through the one compare-subtract
//  unit, and hands the result to the output register that drives m_tvalid.
//  A count past the span takes YEAR_SPAN strips and then a saturating step.
//  s_tready is high only while the sequencer is idle; a result waiting in the
//  output register does not stop the next word being accepted and converted.
//  The sequencer holds a finished result until the output register is free.
//  aresetn is synchronous and active low; it clears the sequencer and m_tvalid.
//
module seconds_to_calendar
    import s2c_pkg::*;
#(
    parameter int YEAR_SPAN = YEAR_SPAN_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // seconds_count[31:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // year, month, day, hour, minute, second, pad
    output logic        m_tuser    // out_of_range
);

    cal_result_t res;
    logic        res_valid;
    logic        res_ready;

    logic        m_tvalid_reg;
    logic [39:0] m_tdata_reg;
    logic        m_tuser_reg;

    // Output register is free when empty or being emptied this cycle
    assign res_ready = !m_tvalid_reg || m_tready;

    s2c_core #(
        .YEAR_SPAN (YEAR_SPAN)
    ) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_count  (s_tdata),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    // Hold the result word until the downstream side takes it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (res_ready) begin
            m_tvalid_reg <= res_valid;
        end
    end

    // Load payload only on transfer from the sequencer
    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            m_tdata_reg <= {7'd0, res.second, res.minute, res.hour,
                            res.day, res.month, res.year};
            m_tuser_reg <= res.out_of_range;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

// File: rtl/s2c_checker.sv
// ----------------------------------------------------------------------------
// s2c_checker - port-level checks for the seconds-to-calendar converter
// Watches the stream ports over time and is bound to the top level.
// ----------------------------------------------------------------------------
module s2c_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata,
    input logic        m_tuser
);

    // Hold a stalled result word
    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result word dropped or changed while stalled");

    // Busy after accepting a word
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted on two consecutive cycles");

    // Every delivered month, day, hour, minute and second lies in its calendar range and the pad is zero
    a_fields_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[10:7] >= 4'd1) && (m_tdata[10:7] <= 4'd12) &&
                     (m_tdata[15:11] >= 5'd1) && (m_tdata[20:16] <= 5'd23) &&
                     (m_tdata[26:21] <= 6'd59) && (m_tdata[32:27] <= 6'd59) &&
                     (m_tdata[39:33] == 7'd0))
        else $error("result field out of calendar range");

    // A saturated word carries the last second of the year
    a_saturated: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> (m_tdata[10:7] == 4'd12) && (m_tdata[15:11] == 5'd31) &&
                                (m_tdata[20:16] == 5'd23) && (m_tdata[26:21] == 6'd59) &&
                                (m_tdata[32:27] == 6'd59))
        else $error("out-of-range word not saturated");

endmodule

bind seconds_to_calendar s2c_checker u_s2c_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// File: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top - self-checking bench for the seconds-to-calendar converter
// Feeds seconds counts into the converter and checks every calendar word it
// returns against a date calculation held in the bench. The counts cover
// hand-picked edges, raw 32-bit values, valid calendar dates and the
// neighbourhood of year, month and span boundaries. Both handshakes are
// throttled at random.
// ----------------------------------------------------------------------------
module tb_top;
    import s2c_pkg::*;

    localparam int     SPAN           = YEAR_SPAN_DEF;
    localparam int     HALF_PERIOD    = 6;
    localparam int     RESET_CYCLES   = 8;
    // Longest quiet spell: a full conversion plus the longest sender gap
    // and receiver stall, taken several times over
    localparam int     WATCHDOG_LIMIT = 5000;
    localparam int     TAIL_CYCLES    = 200;
    localparam int     MAX_REPORTS    = 40;
    localparam longint DAY_SECS       = 86400;
    localparam longint HOUR_SECS      = 3600;
    localparam longint MIN_SECS       = 60;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;   // year, month, day, hour, minute, second, pad
    logic        m_tuser;   // out_of_range

    cal_result_t pending_dates[$];   // dates predicted for accepted counts
    int          error_count   = 0;
    int          counts_sent   = 0;
    int          dates_checked = 0;
    int          saturated     = 0;
    int          idle_cycles   = 0;
    bit          quiet         = 1'b0;   // hold both sides free of gaps

    seconds_to_calendar #(
        .YEAR_SPAN (SPAN)
    ) i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #HALF_PERIOD aclk = ~aclk;

    // ------------------------------------------------------------------
    // Calendar arithmetic
    // ------------------------------------------------------------------

    // Two-digit years divisible by four are leap years, year 00 included
    function automatic bit year_is_leap(input int yr);
        return (yr % 4) == 0;
    endfunction

    function automatic int days_in_year(input int yr);
        return year_is_leap(yr) ? 366 : 365;
    endfunction

    // Month index is zero based here: 0 is January
    function automatic int days_in_month(input int mo0, input bit leap);
        case (mo0)
            1: begin
                return leap ? 29 : 28;
            end
            3, 5, 8, 10: begin
                return 30;
            end
            default: begin
                return 31;
            end
        endcase
    endfunction

    // Seconds count of a calendar instant; month and day are one based
    function automatic longint secs_at(input int yr, input int mo, input int dy,
                                       input int hh, input int mm, input int ss);
        longint total;
        total = 0;
        for (int y = 0; y < yr; y++) begin
            total += longint'(days_in_year(y)) * DAY_SECS;
        end
        for (int m = 0; m < mo - 1; m++) begin
            total += longint'(days_in_month(m, year_is_leap(yr))) * DAY_SECS;
        end
        total += longint'(dy - 1) * DAY_SECS + hh * HOUR_SECS + mm * MIN_SECS + ss;
        return total;
    endfunction

    // Expected calendar word for one seconds count: strip whole years, then
    // whole months, then split the rest by constant division. Running off
    // the end of the span pins the date to the last second of the span.
    function automatic cal_result_t calendar_of(input logic [31:0] secs);
        longint      rest;
        int          yr;
        int          mo;
        bit          leap;
        cal_result_t r;
        rest = longint'(secs);
        yr   = 0;
        while (yr < SPAN && rest >= longint'(days_in_year(yr)) * DAY_SECS) begin
            rest -= longint'(days_in_year(yr)) * DAY_SECS;
            yr++;
        end
        if (yr == SPAN) begin
            r.year         = 7'(SPAN - 1);
            r.month        = 4'd12;
            r.day          = 5'd31;
            r.hour         = 5'd23;
            r.minute       = 6'd59;
            r.second       = 6'd59;
            r.out_of_range = 1'b1;
        end else begin
            leap = year_is_leap(yr);
            mo   = 0;
            while (mo < 12 && rest >= longint'(days_in_month(mo, leap)) * DAY_SECS) begin
                rest -= longint'(days_in_month(mo, leap)) * DAY_SECS;
                mo++;
            end
            r.year         = 7'(yr);
            r.month        = 4'(mo + 1);
            r.day          = 5'(rest / DAY_SECS + 1);
            rest           = rest % DAY_SECS;
            r.hour         = 5'(rest / HOUR_SECS);
            rest           = rest % HOUR_SECS;
            r.minute       = 6'(rest / MIN_SECS);
            r.second       = 6'(rest % MIN_SECS);
            r.out_of_range = 1'b0;
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Handshake helpers
    // ------------------------------------------------------------------

    // Mostly no gap, often a short one, now and then a long one that
    // can outlast a whole conversion
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 4);
        end
        return $urandom_range(10, 150);
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        if (error_count < MAX_REPORTS) begin
            $display("tb_top: mismatch on %s: got %0d, expected %0d (result word %0d)",
                     what, got, want, dates_checked);
        end
        error_count++;
    endtask

    // Offer one count and hold it until the converter takes it; valid stays
    // high afterwards so that a following word can go out without a gap
    task automatic send_count(input logic [31:0] secs);
        int          gap;
        cal_result_t want;
        gap = quiet ? 0 : gap_len();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= secs;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        want = calendar_of(secs);
        pending_dates.push_back(want);
        counts_sent++;
        if (want.out_of_range) begin
            saturated++;
        end
    endtask

    // Random date inside the span, leaning towards month ends and the
    // extremes of the time of day
    function automatic logic [31:0] random_date();
        int yr;
        int mo;
        int dy;
        int hh;
        int mm;
        int ss;
        int len;
        yr  = $urandom_range(0, SPAN - 1);
        mo  = $urandom_range(1, 12);
        len = days_in_month(mo - 1, year_is_leap(yr));
        case ($urandom_range(0, 9))
            0, 1:    dy = len;
            2:       dy = 1;
            default: dy = $urandom_range(1, len);
        endcase
        hh = ($urandom_range(0, 4) == 0) ? 23 * $urandom_range(0, 1) : $urandom_range(0, 23);
        mm = ($urandom_range(0, 4) == 0) ? 59 * $urandom_range(0, 1) : $urandom_range(0, 59);
        ss = ($urandom_range(0, 4) == 0) ? 59 * $urandom_range(0, 1) : $urandom_range(0, 59);
        return 32'(secs_at(yr, mo, dy, hh, mm, ss));
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Hand-picked edges: unit rollovers, month ends in leap and normal years,
    // the last second of the span, the first seconds past it and the
    // extremes of the 32-bit count
    task automatic test_directed();
        longint span_end;
        span_end = secs_at(SPAN, 1, 1, 0, 0, 0);
        send_count(32'd0);
        send_count(32'd1);
        send_count(32'd59);
        send_count(32'd60);
        send_count(32'd3599);
        send_count(32'd3600);
        send_count(32'd86399);
        send_count(32'd86400);
        send_count(32'(secs_at(0, 1, 31, 23, 59, 59)));
        send_count(32'(secs_at(0, 2, 1, 0, 0, 0)));
        send_count(32'(secs_at(0, 2, 29, 12, 34, 56)));
        send_count(32'(secs_at(0, 3, 1, 0, 0, 0)));
        send_count(32'(secs_at(1, 2, 28, 23, 59, 59)));
        send_count(32'(secs_at(1, 3, 1, 0, 0, 0)));
        send_count(32'(secs_at(0, 12, 31, 23, 59, 59)));
        send_count(32'(secs_at(1, 1, 1, 0, 0, 0)));
        send_count(32'(secs_at(4, 2, 29, 0, 0, 0)));
        send_count(32'(secs_at(SPAN - 1, 12, 31, 23, 59, 59)));
        send_count(32'(span_end));
        send_count(32'(span_end + 1));
        send_count(32'h7FFF_FFFF);
        send_count(32'h8000_0000);
        send_count(32'hFFFF_FFFF);
        send_count(32'hAAAA_AAAA);
        send_count(32'h5555_5555);
    endtask

    // Back-to-back words with neither side idling
    task automatic test_back_to_back();
        quiet = 1'b1;
        for (int i = 0; i < 100; i++) begin
            send_count(i[0] ? $urandom() : random_date());
        end
        quiet = 1'b0;
    endtask

    // Raw 32-bit counts; roughly a quarter of them fall past the span
    task automatic test_raw_counts();
        for (int i = 0; i < 300; i++) begin
            send_count($urandom());
        end
    endtask

    task automatic test_calendar_dates();
        for (int i = 0; i < 700; i++) begin
            send_count(random_date());
        end
    endtask

    // Counts a few seconds either side of a month start, with an occasional
    // visit to the end of the span
    task automatic test_boundaries();
        longint base;
        longint span_end;
        span_end = secs_at(SPAN, 1, 1, 0, 0, 0);
        for (int i = 0; i < 300; i++) begin
            if ($urandom_range(0, 7) == 0) begin
                base = span_end;
            end else begin
                base = secs_at($urandom_range(0, SPAN - 1), $urandom_range(1, 12), 1, 0, 0, 0);
            end
            base += $urandom_range(0, 8) - 4;
            if (base < 0) begin
                base = 0;
            end
            send_count(32'(base));
        end
    endtask

    // ------------------------------------------------------------------
    // Result side
    // ------------------------------------------------------------------

    // Throttle the result channel: stalls of random length between bursts
    initial begin
        int stall;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            stall = quiet ? 0 : gap_len();
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
        end
    end

    // Compare each accepted word with the oldest pending date
    always @(posedge aclk) begin
        cal_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_dates.size() == 0) begin
                report_mismatch("word with no count pending", m_tdata, 0);
            end else begin
                want = pending_dates.pop_front();
                if (m_tdata[6:0] !== want.year) begin
                    report_mismatch("year", m_tdata[6:0], want.year);
                end
                if (m_tdata[10:7] !== want.month) begin
                    report_mismatch("month", m_tdata[10:7], want.month);
                end
                if (m_tdata[15:11] !== want.day) begin
                    report_mismatch("day", m_tdata[15:11], want.day);
                end
                if (m_tdata[20:16] !== want.hour) begin
                    report_mismatch("hour", m_tdata[20:16], want.hour);
                end
                if (m_tdata[26:21] !== want.minute) begin
                    report_mismatch("minute", m_tdata[26:21], want.minute);
                end
                if (m_tdata[32:27] !== want.second) begin
                    report_mismatch("second", m_tdata[32:27], want.second);
                end
                if (m_tuser !== want.out_of_range) begin
                    report_mismatch("out_of_range", m_tuser, want.out_of_range);
                end
            end
            dates_checked++;
        end
    end

    // Abort when neither channel moves a word for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_top: no handshake for %0d cycles, %0d dates still pending",
                     WATCHDOG_LIMIT, pending_dates.size());
            $display("tb_top: done, errors");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_back_to_back();
        test_raw_counts();
        test_calendar_dates();
        test_boundaries();

        // Drop valid, drain what is still in flight, then allow a spell for
        // any stray word to show up
        s_tvalid <= 1'b0;
        while (pending_dates.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("tb_top: %0d counts converted, %0d words checked, %0d past the end of the span",
                 counts_sent, dates_checked, saturated);
        $display("tb_top: edges, leap days, month and span boundaries, raw counts, random stalls");
        if (error_count == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: %0d mismatches", error_count);
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule

// File: seconds_to_calendar.f
rtl/s2c_pkg.sv
rtl/s2c_alu.sv
rtl/s2c_core.sv
rtl/seconds_to_calendar.sv
rtl/s2c_checker.sv
tb/tb_top.sv
